>>> hw/rtl/dtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtr_pkg;

  // Sizes of the ranging arithmetic
  localparam int TS_W      = 32;            // radio timestamp
  localparam int DLY_W     = 16;            // half antenna delay
  localparam int SCALE_W   = 24;            // mm per tick, Q16
  localparam int GAIN_W    = 17;            // filter gain, Q16
  localparam int CNT_CFG_W = 4;             // anchor count register
  localparam int IDX_IN_W  = 3;             // anchor index field
  localparam int PROD_W    = 2 * TS_W;      // interval product
  localparam int DEN_W     = TS_W + 2;      // sum of four intervals
  localparam int NUM_W     = PROD_W + SCALE_W; // scaled magnitude
  localparam int QUO_W     = 41;            // quotient bits kept
  localparam int DIV_STEPS = QUO_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int MM_W      = 24;            // distance in mm
  localparam int FPROD_W   = GAIN_W + 1 + MM_W + 1;

  localparam int NUM_ANCHORS_DEF = 8;

  // Saturation limits and filter constants
  localparam logic [MM_W:0]       SAT_POS_MAG = 25'd8388607;
  localparam logic [MM_W:0]       SAT_NEG_MAG = 25'd8388608;
  localparam logic [MM_W-1:0]     SAT_POS     = 24'h7FFFFF;
  localparam logic [MM_W-1:0]     SAT_NEG     = 24'h800000;
  localparam logic [GAIN_W-1:0]   GAIN_ONE    = 17'h10000;
  localparam logic [FPROD_W-1:0]  ROUND_HALF  = FPROD_W'(32768);

  // Register reset values
  localparam logic [DLY_W-1:0]     ANT_DLY_RST = 16'd16476;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = 24'd307477;
  localparam logic [GAIN_W-1:0]    GAIN_RST    = 17'd6554;
  localparam logic [CNT_CFG_W-1:0] ANC_CNT_RST = 4'd3;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_ANT_DLY = 2'd0,
    REG_SCALE   = 2'd1,
    REG_GAIN    = 2'd2,
    REG_ANC_CNT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_ROUND,
    OP_MUL_REPLY,
    OP_DIFF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_CHECK,
    OP_DIV,
    OP_POST,
    OP_FILT_MUL,
    OP_FILT_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
  } dp_stat_t;

  typedef struct packed {
    logic [DLY_W-1:0]     ant_dly;
    logic [SCALE_W-1:0]   scale;
    logic [GAIN_W-1:0]    gain;
    logic [CNT_CFG_W-1:0] anc_cnt;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module dtr_cfg
  import dtr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t sel;
  logic     wr_en;

  assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Decode the write word into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (sel)
        REG_ANT_DLY: cfg_nxt.ant_dly = pwdata[DLY_W-1:0];
        REG_SCALE:   cfg_nxt.scale   = pwdata[SCALE_W-1:0];
        REG_GAIN:    cfg_nxt.gain    = pwdata[GAIN_W-1:0];
        REG_ANC_CNT: cfg_nxt.anc_cnt = pwdata[CNT_CFG_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ant_dly <= ANT_DLY_RST;
      cfg_r.scale   <= SCALE_RST;
      cfg_r.gain    <= GAIN_RST;
      cfg_r.anc_cnt <= ANC_CNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (sel)
      REG_ANT_DLY: prdata = PDATA_W'(cfg_r.ant_dly);
      REG_SCALE:   prdata = PDATA_W'(cfg_r.scale);
      REG_GAIN:    prdata = PDATA_W'(cfg_r.gain);
      REG_ANC_CNT: prdata = PDATA_W'(cfg_r.anc_cnt);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/dtr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dtr_ctrl
  import dtr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output cmd_t          cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL1  = 12'b0000_0000_0010,
    S_MUL2  = 12'b0000_0000_0100,
    S_DIFF  = 12'b0000_0000_1000,
    S_MUL3  = 12'b0000_0001_0000,
    S_MUL4  = 12'b0000_0010_0000,
    S_SUM   = 12'b0000_0100_0000,
    S_CHECK = 12'b0000_1000_0000,
    S_DIV   = 12'b0001_0000_0000,
    S_POST  = 12'b0010_0000_0000,
    S_FMUL  = 12'b0100_0000_0000,
    S_FOUT  = 12'b1000_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequence the steps of one exchange
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op    = OP_MUL_ROUND;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = OP_MUL_REPLY;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = S_MUL4;
      end
      S_MUL4: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op  = OP_CHECK;
        cnt_nxt = '0;
        if (stat.skip_div) begin
          state_nxt = S_POST;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        cmd.op    = OP_POST;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        // hold here while the previous word is still unread
        cmd.op = OP_FILT_MUL;
        if (out_free) begin
          state_nxt = S_FOUT;
        end
      end
      S_FOUT: begin
        cmd.op    = OP_FILT_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_FOUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dtr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dtr_dp
  import dtr_pkg::*;
#(
  parameter int NUM_ANCHORS = NUM_ANCHORS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output dp_stat_t                 stat,
  input  wire cfg_t                cfg,
  input  wire logic [IDX_IN_W-1:0] in_anchor_index,
  input  wire logic [TS_W-1:0]     in_poll_tx_time,
  input  wire logic [TS_W-1:0]     in_poll_rx_time,
  input  wire logic [TS_W-1:0]     in_answer_tx_time,
  input  wire logic [TS_W-1:0]     in_answer_rx_time,
  input  wire logic [TS_W-1:0]     in_final_tx_time,
  input  wire logic [TS_W-1:0]     in_final_rx_time,
  output logic [IDX_IN_W-1:0]      out_anchor_echo,
  output logic signed [MM_W-1:0]   out_raw_distance_mm,
  output logic signed [MM_W-1:0]   out_filtered_distance_mm,
  output logic [1:0]               out_status
);

  localparam int IDX_W = $clog2(NUM_ANCHORS);
  // wide enough for both the count register and the anchor total
  localparam int LIM_W = ((CNT_CFG_W > $clog2(NUM_ANCHORS + 1)) ?
                          CNT_CFG_W : $clog2(NUM_ANCHORS + 1)) + 1;

  // Exchange registers
  logic [IDX_IN_W-1:0] idx_r;
  logic [TS_W-1:0]     round1_r, reply1_r, round2_r, reply2_r;
  logic [DEN_W-1:0]    den_r;
  logic [PROD_W-1:0]   prod_r, p1_r, mag_r, lo_r;
  logic                neg_r;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic                zero_r, esat_r;
  logic [MM_W-1:0]     raw_r;
  status_t             st_r;
  logic signed [FPROD_W-1:0] fprod_r;

  // Filter store, cleared at reset
  logic [MM_W-1:0] filt_mem_r [NUM_ANCHORS];

  // Output word
  logic [IDX_IN_W-1:0] echo_r;
  logic [MM_W-1:0]     raw_out_r, filt_out_r;
  status_t             st_out_r;

  // Corrected timestamps
  logic [TS_W-1:0] dly, ptx, arx, ftx;
  assign dly = TS_W'(cfg.ant_dly);
  assign ptx = in_poll_tx_time + dly;
  assign arx = in_answer_rx_time - dly;
  assign ftx = in_final_tx_time + dly;

  // Shared multiplier operands
  logic [TS_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    case (cmd.op)
      OP_MUL_ROUND: begin
        mul_a = round1_r;
        mul_b = round2_r;
      end
      OP_MUL_REPLY: begin
        mul_a = reply1_r;
        mul_b = reply2_r;
      end
      OP_MUL_LO: begin
        mul_a = mag_r[TS_W-1:0];
        mul_b = TS_W'(cfg.scale);
      end
      default: begin
        mul_a = mag_r[PROD_W-1:TS_W];
        mul_b = TS_W'(cfg.scale);
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Overflow test: quotient would reach 2^QUO_W
  logic early_sat, den_zero;
  assign den_zero  = (den_r == '0);
  assign early_sat = num_r[NUM_W-1:QUO_W] >= (NUM_W - QUO_W)'(den_r);
  assign stat.skip_div = den_zero || early_sat;

  // One restoring division step
  logic [DEN_W:0] rem_sh, rem_sub;
  logic           rem_ge;
  assign rem_sh  = {rem_r, num_r[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_ge  = rem_sh >= {1'b0, den_r};

  // Scale result, saturation and range check
  logic [MM_W:0]    mm;
  logic             over, sat;
  logic [MM_W-1:0]  raw_nxt;
  status_t          st_nxt;
  logic [LIM_W-1:0] lim;
  logic             idx_ok;
  assign mm   = quo_r[QUO_W-1:16];
  assign over = neg_r ? (mm > SAT_NEG_MAG) : (mm > SAT_POS_MAG);
  assign sat  = esat_r || over;
  assign lim  = (LIM_W'(cfg.anc_cnt) < LIM_W'(NUM_ANCHORS)) ?
                LIM_W'(cfg.anc_cnt) : LIM_W'(NUM_ANCHORS);
  assign idx_ok = LIM_W'(idx_r) < lim;

  always_comb begin
    if (zero_r) begin
      raw_nxt = '0;
      st_nxt  = ST_ZERO;
    end else if (sat) begin
      raw_nxt = neg_r ? SAT_NEG : SAT_POS;
      st_nxt  = ST_SAT;
    end else begin
      raw_nxt = neg_r ? (MM_W'(0) - mm[MM_W-1:0]) : mm[MM_W-1:0];
      st_nxt  = ST_OK;
    end
    if (!idx_ok) begin
      st_nxt = ST_BAD;
    end
  end

  // Low-pass: old + round(g * (raw - old) / 2^16)
  logic [IDX_W-1:0]          sel;
  logic [MM_W-1:0]           old;
  logic [GAIN_W-1:0]         gain;
  logic signed [MM_W:0]      fdiff;
  logic signed [FPROD_W-1:0] frnd, fsh;
  logic [MM_W-1:0]           fnew;
  logic                      fupd;
  assign sel   = IDX_W'(idx_r);
  assign old   = filt_mem_r[sel];
  assign gain  = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;
  assign fdiff = $signed({raw_r[MM_W-1], raw_r}) - $signed({old[MM_W-1], old});
  assign frnd  = fprod_r + $signed(ROUND_HALF);
  assign fsh   = frnd >>> 16;
  assign fnew  = old + fsh[MM_W-1:0];
  assign fupd  = (st_r == ST_OK) || (st_r == ST_SAT);

  // Datapath registers, advanced by command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        idx_r    <= in_anchor_index;
        round1_r <= arx - ptx;
        reply1_r <= in_answer_tx_time - in_poll_rx_time;
        round2_r <= in_final_rx_time - in_answer_tx_time;
        reply2_r <= ftx - arx;
      end
      OP_MUL_ROUND: begin
        prod_r <= mul_p;
        den_r  <= DEN_W'(round1_r) + DEN_W'(round2_r) + DEN_W'(reply1_r) + DEN_W'(reply2_r);
      end
      OP_MUL_REPLY: begin
        p1_r   <= prod_r;
        prod_r <= mul_p;
      end
      OP_DIFF: begin
        neg_r <= p1_r < prod_r;
        mag_r <= (p1_r < prod_r) ? (prod_r - p1_r) : (p1_r - prod_r);
      end
      OP_MUL_LO: begin
        prod_r <= mul_p;
      end
      OP_MUL_HI: begin
        lo_r   <= prod_r;
        prod_r <= mul_p;
      end
      OP_SUM: begin
        num_r <= {prod_r[NUM_W-TS_W-1:0], TS_W'(0)} + NUM_W'(lo_r);
      end
      OP_CHECK: begin
        zero_r <= den_zero;
        esat_r <= early_sat;
        rem_r  <= num_r[QUO_W+DEN_W-1:QUO_W];
        quo_r  <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], rem_ge};
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
      OP_POST: begin
        raw_r <= raw_nxt;
        st_r  <= st_nxt;
      end
      OP_FILT_MUL: begin
        fprod_r <= $signed({1'b0, gain}) * fdiff;
      end
      OP_FILT_OUT: begin
        echo_r    <= idx_r;
        raw_out_r <= raw_r;
        st_out_r  <= st_r;
        if (st_r == ST_BAD) begin
          filt_out_r <= '0;
        end else if (st_r == ST_ZERO) begin
          filt_out_r <= old;
        end else begin
          filt_out_r <= fnew;
        end
      end
      default: ;
    endcase
  end

  // Filter store update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ANCHORS; i++) begin
        filt_mem_r[i] <= '0;
      end
    end else if (cmd.op == OP_FILT_OUT && fupd) begin
      filt_mem_r[sel] <= fnew;
    end
  end

  assign out_anchor_echo          = echo_r;
  assign out_raw_distance_mm      = $signed(raw_out_r);
  assign out_filtered_distance_mm = $signed(filt_out_r);
  assign out_status               = st_out_r;

endmodule

`default_nettype wire

>>> hw/rtl/ds_twr_range_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-sided two-way ranging distance with a per-anchor low-pass filter.
// Input channel (in_*): one finished exchange per word, the anchor index and
// six 32-bit timestamps. Result channel (out_*): one word per input word, with
// the anchor echo, raw and filtered distance in mm, and a status code.
// Registers sit on an APB-style port (psel/penable/pwrite/paddr/pwdata),
// one register every 4 bytes; pready is always high. Write them only while
// the block is idle.
// An item runs load, two interval products, difference, two scaling
// products, sum, check, the 41-step restoring divider, post, filter multiply
// and filter output; the divider is skipped when the interval sum is zero or
// the quotient overflows early. The shared 32x32 multiplier takes four steps.
// in_ready is high whenever no item is in flight, so a new word is taken
// while the previous result still waits in the output register. When the
// receiver stalls, the next result holds just before its filter update until
// the output register empties.
// Reset (synchronous, active low) restores the register defaults and clears
// every anchor's filter value to zero.
module ds_twr_range_filter
  import dtr_pkg::*;
#(
  parameter int NUM_ANCHORS = NUM_ANCHORS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IDX_IN_W-1:0]  in_anchor_index,
  input  wire logic [TS_W-1:0]      in_poll_tx_time,
  input  wire logic [TS_W-1:0]      in_poll_rx_time,
  input  wire logic [TS_W-1:0]      in_answer_tx_time,
  input  wire logic [TS_W-1:0]      in_answer_rx_time,
  input  wire logic [TS_W-1:0]      in_final_tx_time,
  input  wire logic [TS_W-1:0]      in_final_rx_time,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [IDX_IN_W-1:0]       out_anchor_echo,
  output logic signed [MM_W-1:0]    out_raw_distance_mm,
  output logic signed [MM_W-1:0]    out_filtered_distance_mm,
  output logic [1:0]                out_status,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  cfg_t     cfg;
  cmd_t     cmd;
  dp_stat_t stat;

  dtr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtr_dp #(
    .NUM_ANCHORS (NUM_ANCHORS)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .stat                     (stat),
    .cfg                      (cfg),
    .in_anchor_index          (in_anchor_index),
    .in_poll_tx_time          (in_poll_tx_time),
    .in_poll_rx_time          (in_poll_rx_time),
    .in_answer_tx_time        (in_answer_tx_time),
    .in_answer_rx_time        (in_answer_rx_time),
    .in_final_tx_time         (in_final_tx_time),
    .in_final_rx_time         (in_final_rx_time),
    .out_anchor_echo          (out_anchor_echo),
    .out_raw_distance_mm      (out_raw_distance_mm),
    .out_filtered_distance_mm (out_filtered_distance_mm),
    .out_status               (out_status)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

import dtr_pkg::*;

// One ranging exchange as it enters the block
typedef struct packed {
  logic [IDX_IN_W-1:0] idx;
  logic [TS_W-1:0]     poll_tx;
  logic [TS_W-1:0]     poll_rx;
  logic [TS_W-1:0]     ans_tx;
  logic [TS_W-1:0]     ans_rx;
  logic [TS_W-1:0]     fin_tx;
  logic [TS_W-1:0]     fin_rx;
} exchange_t;

// One range word as it leaves the block
typedef struct {
  logic [IDX_IN_W-1:0]    anchor;
  logic signed [MM_W-1:0] raw;
  logic signed [MM_W-1:0] filt;
  logic [1:0]             status;
} range_result_t;

class range_scoreboard;
  logic [DLY_W-1:0]       ant_dly;
  logic [SCALE_W-1:0]     scale;
  logic [GAIN_W-1:0]      gain;
  logic [CNT_CFG_W-1:0]   anc_cnt;
  logic signed [MM_W-1:0] filt_mem [NUM_ANCHORS_DEF];
  range_result_t          expected_q [$];
  int unsigned            mismatches;

  function new();
    ant_dly    = ANT_DLY_RST;
    scale      = SCALE_RST;
    gain       = GAIN_RST;
    anc_cnt    = ANC_CNT_RST;
    mismatches = 0;
    foreach (filt_mem[i]) filt_mem[i] = '0;
  endfunction

  // Mirror a register write, keeping only the register's own bits
  function void set_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
    case (r)
      REG_ANT_DLY: ant_dly = v[DLY_W-1:0];
      REG_SCALE:   scale   = v[SCALE_W-1:0];
      REG_GAIN:    gain    = v[GAIN_W-1:0];
      REG_ANC_CNT: anc_cnt = v[CNT_CFG_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Work out the range word for an accepted exchange and queue it
  function void note_exchange(exchange_t e);
    logic [TS_W-1:0]        ptx, arx, ftx, round1, reply1, round2, reply2;
    logic [PROD_W-1:0]      p1, p2, mag;
    logic [DEN_W-1:0]       den;
    logic [95:0]            mm;
    logic                   neg;
    logic signed [MM_W-1:0] raw;
    int unsigned            lim;
    longint                 g, acc;
    range_result_t          r;
    ptx    = e.poll_tx + TS_W'(ant_dly);
    arx    = e.ans_rx - TS_W'(ant_dly);
    ftx    = e.fin_tx + TS_W'(ant_dly);
    round1 = arx - ptx;
    reply1 = e.ans_tx - e.poll_rx;
    round2 = e.fin_rx - e.ans_tx;
    reply2 = ftx - arx;
    p1     = PROD_W'(round1) * PROD_W'(round2);
    p2     = PROD_W'(reply1) * PROD_W'(reply2);
    den    = DEN_W'(round1) + DEN_W'(reply1) + DEN_W'(round2) + DEN_W'(reply2);
    raw    = '0;
    r.anchor = e.idx;
    r.filt   = '0;
    r.status = ST_OK;
    // Exact truncated quotient, then clamp to 24 bits
    if (den == '0) begin
      r.status = ST_ZERO;
    end else begin
      neg = p1 < p2;
      mag = neg ? p2 - p1 : p1 - p2;
      mm  = ((96'(mag) * 96'(scale)) / 96'(den)) >> 16;
      if (neg ? mm > 96'(SAT_NEG_MAG) : mm > 96'(SAT_POS_MAG)) begin
        r.status = ST_SAT;
        raw = neg ? SAT_NEG : SAT_POS;
      end else begin
        raw = neg ? -mm[MM_W-1:0] : mm[MM_W-1:0];
      end
    end
    r.raw = raw;
    // Reject the index, hold the filter, or advance it
    lim = anc_cnt < NUM_ANCHORS_DEF ? anc_cnt : NUM_ANCHORS_DEF;
    if (e.idx >= lim) begin
      r.status = ST_BAD;
    end else if (r.status == ST_ZERO) begin
      r.filt = filt_mem[e.idx];
    end else begin
      g   = gain > GAIN_ONE ? 64'sd65536 : longint'(gain);
      acc = g * longint'(raw) + (64'sd65536 - g) * longint'(filt_mem[e.idx]) + 64'sd32768;
      filt_mem[e.idx] = MM_W'(acc >>> 16);
      r.filt = filt_mem[e.idx];
    end
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Compare a range word with the oldest one waiting
  task check_result(range_result_t got);
    range_result_t w;
    if (expected_q.size() == 0) begin
      report($sformatf("range word for anchor %0d with none pending", got.anchor));
      return;
    end
    w = expected_q.pop_front();
    if (got.anchor !== w.anchor)
      report($sformatf("anchor got %0d want %0d", got.anchor, w.anchor));
    if (got.raw !== w.raw)
      report($sformatf("anchor %0d raw got %0d want %0d", w.anchor, got.raw, w.raw));
    if (got.filt !== w.filt)
      report($sformatf("anchor %0d filtered got %0d want %0d", w.anchor, got.filt, w.filt));
    if (got.status !== w.status)
      report($sformatf("anchor %0d status got %0d want %0d", w.anchor, got.status, w.status));
  endtask
endclass

module tb;
  import dtr_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [IDX_IN_W-1:0]    in_anchor_index;
  logic [TS_W-1:0]        in_poll_tx_time;
  logic [TS_W-1:0]        in_poll_rx_time;
  logic [TS_W-1:0]        in_answer_tx_time;
  logic [TS_W-1:0]        in_answer_rx_time;
  logic [TS_W-1:0]        in_final_tx_time;
  logic [TS_W-1:0]        in_final_rx_time;
  logic                   out_valid;
  logic                   out_ready;
  logic [IDX_IN_W-1:0]    out_anchor_echo;
  logic signed [MM_W-1:0] out_raw_distance_mm;
  logic signed [MM_W-1:0] out_filtered_distance_mm;
  logic [1:0]             out_status;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  range_scoreboard sb;
  range_result_t   got;
  bit              quiet;
  int              stall_left = 0;

  ds_twr_range_filter #(
    .NUM_ANCHORS(NUM_ANCHORS_DEF)
  ) DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_anchor_index          (in_anchor_index),
    .in_poll_tx_time          (in_poll_tx_time),
    .in_poll_rx_time          (in_poll_rx_time),
    .in_answer_tx_time        (in_answer_tx_time),
    .in_answer_rx_time        (in_answer_rx_time),
    .in_final_tx_time         (in_final_tx_time),
    .in_final_rx_time         (in_final_rx_time),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_anchor_echo          (out_anchor_echo),
    .out_raw_distance_mm      (out_raw_distance_mm),
    .out_filtered_distance_mm (out_filtered_distance_mm),
    .out_status               (out_status),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: mostly ready, short stalls now and then, an occasional long one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 199) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every range word taken from the block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.anchor = out_anchor_echo;
      got.raw    = out_raw_distance_mm;
      got.filt   = out_filtered_distance_mm;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  // Build an exchange from its four intervals, with random clock origins
  function automatic exchange_t make_exch(logic [IDX_IN_W-1:0] idx, logic [TS_W-1:0] r1,
                                          logic [TS_W-1:0] d1, logic [TS_W-1:0] r2,
                                          logic [TS_W-1:0] d2);
    logic [TS_W-1:0] ptx, prx, arx, atx;
    exchange_t e;
    ptx = $urandom;
    prx = $urandom;
    arx = ptx + r1;
    atx = prx + d1;
    e.idx     = idx;
    e.poll_tx = ptx - TS_W'(sb.ant_dly);
    e.poll_rx = prx;
    e.ans_tx  = atx;
    e.ans_rx  = arx + TS_W'(sb.ant_dly);
    e.fin_tx  = arx + d2 - TS_W'(sb.ant_dly);
    e.fin_rx  = atx + r2;
    return e;
  endfunction

  // A physically sensible exchange: flight time tof, reply times d1 and d2, small jitter
  function automatic exchange_t ranging_exch(logic [IDX_IN_W-1:0] idx, int tof,
                                             logic [TS_W-1:0] d1, logic [TS_W-1:0] d2);
    logic [TS_W-1:0] flight2;
    flight2 = TS_W'(2 * tof);
    return make_exch(idx, flight2 + d1 + TS_W'($urandom_range(0, 6)) - 32'd3, d1,
                     flight2 + d2 + TS_W'($urandom_range(0, 6)) - 32'd3, d2);
  endfunction

  // Present one word, with an occasional gap first, and hold it until taken
  task automatic send_exchange(input exchange_t e);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 7) ? $urandom_range(1, 70) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_anchor_index   <= e.idx;
    in_poll_tx_time   <= e.poll_tx;
    in_poll_rx_time   <= e.poll_rx;
    in_answer_tx_time <= e.ans_tx;
    in_answer_rx_time <= e.ans_rx;
    in_final_tx_time  <= e.fin_tx;
    in_final_rx_time  <= e.fin_rx;
    do @(posedge clk); while (!in_ready);
    sb.note_exchange(e);
  endtask

  task automatic apb_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, drain every pending range word, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    exchange_t            e;
    logic [TS_W-1:0]      d1, d2;
    logic [PDATA_W-1:0]   junk;
    logic [IDX_IN_W-1:0]  idx;
    logic [DLY_W-1:0]     dly_v;
    logic [SCALE_W-1:0]   scale_v;
    logic [GAIN_W-1:0]    gain_v;
    logic [CNT_CFG_W-1:0] cnt_v;
    int                   tof, kind, lim;

    sb                = new();
    quiet             = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_anchor_index   = '0;
    in_poll_tx_time   = '0;
    in_poll_rx_time   = '0;
    in_answer_tx_time = '0;
    in_answer_rx_time = '0;
    in_final_tx_time  = '0;
    in_final_rx_time  = '0;
    out_ready         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings
    send_exchange(make_exch(0, 0, 0, 0, 0));                 // zero interval sum, fresh filter
    send_exchange(ranging_exch(0, 1000, 200000, 200000));
    send_exchange(ranging_exch(1, 3000, 100000, 900000));    // asymmetric replies
    send_exchange(ranging_exch(2, 0, 250000, 250000));
    send_exchange(ranging_exch(2, -100, 250000, 260000));    // negative distance
    send_exchange(ranging_exch(3, 500, 200000, 200000));     // index beyond anchor count
    send_exchange(ranging_exch(7, 500, 200000, 200000));
    send_exchange(make_exch(0, 0, 0, 0, 0));                 // zero sum holds the filter
    send_exchange(make_exch(6, 0, 0, 0, 0));                 // zero sum and bad index
    send_exchange(make_exch(1, 32'h8000_0000, 0, 32'h8000_0000, 0));  // positive clamp
    send_exchange(make_exch(1, 0, 32'h8000_0000, 0, 32'h8000_0000));  // negative clamp
    send_exchange(make_exch(2, '1, 0, '1, 0));               // largest products
    send_exchange(make_exch(5, 32'h8000_0000, 0, 32'h8000_0000, 0));  // clamp, bad index
    e = '1;
    send_exchange(e);
    e = '0;
    send_exchange(e);

    // Gain beyond unity and an anchor count of zero
    wait_idle();
    apb_write(REG_GAIN, 32'h0001_FFFF);
    apb_write(REG_ANC_CNT, 32'd0);
    send_exchange(ranging_exch(0, 800, 150000, 150000));
    wait_idle();
    apb_write(REG_ANC_CNT, 32'd8);
    send_exchange(ranging_exch(7, 1200, 150000, 170000));
    send_exchange(ranging_exch(0, 1200, 150000, 170000));

    // Random phases, each under its own register settings
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          dly_v = '0; scale_v = '1; gain_v = GAIN_ONE; cnt_v = 4'd8;
        end
        1: begin
          dly_v = '1; scale_v = '0; gain_v = '0; cnt_v = 4'd1;
        end
        2: begin
          dly_v = DLY_W'($urandom); scale_v = SCALE_W'($urandom); gain_v = '1; cnt_v = 4'd0;
        end
        3: begin
          dly_v = DLY_W'($urandom); scale_v = SCALE_RST; gain_v = GAIN_ONE - 1'b1;
          cnt_v = 4'd15;
        end
        default: begin
          dly_v   = DLY_W'($urandom);
          scale_v = SCALE_W'(($urandom_range(0, 1) == 0) ? $urandom_range(200000, 400000)
                                                          : $urandom);
          gain_v  = GAIN_W'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 65536));
          cnt_v   = CNT_CFG_W'($urandom_range(0, 15));
        end
      endcase
      quiet = (ph == 5);
      // later phases put junk above each register's width
      junk = (ph >= 4) ? $urandom : '0;
      apb_write(REG_ANT_DLY, {junk[PDATA_W-1:DLY_W], dly_v});
      apb_write(REG_SCALE, {junk[PDATA_W-1:SCALE_W], scale_v});
      apb_write(REG_GAIN, {junk[PDATA_W-1:GAIN_W], gain_v});
      apb_write(REG_ANC_CNT, {junk[PDATA_W-1:CNT_CFG_W], cnt_v});
      lim = cnt_v < NUM_ANCHORS_DEF ? cnt_v : NUM_ANCHORS_DEF;

      for (int n = 0; n < 240; n++) begin
        // hold off mid-phase until every range word is back
        if (n == 120) wait_idle();
        idx = (lim != 0 && $urandom_range(0, 9) < 8) ? IDX_IN_W'($urandom_range(0, lim - 1))
                                                     : IDX_IN_W'($urandom_range(0, 7));
        d1  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24'hFF_FFFF);
        d2  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24'hFF_FFFF);
        tof = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 24'hFF_FFFF))
                                          : int'($urandom_range(0, 4200)) - 200;
        kind = $urandom_range(0, 99);
        e = ranging_exch(idx, tof, d1, d2);
        if (kind >= 95) begin
          e = make_exch(idx, 0, 0, 0, 0);
        end else if (kind >= 85) begin
          // break one timestamp of an otherwise sound exchange
          case ($urandom_range(0, 5))
            0: e.poll_tx = $urandom;
            1: e.poll_rx = $urandom;
            2: e.ans_tx  = $urandom;
            3: e.ans_rx  = $urandom;
            4: e.fin_tx  = $urandom;
            default: e.fin_rx = $urandom;
          endcase
        end else if (kind >= 70) begin
          e = {IDX_IN_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        end
        send_exchange(e);
      end
    end

    quiet = 1'b0;
    wait_idle();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dtr_pkg.sv
hw/rtl/dtr_cfg.sv
hw/rtl/dtr_ctrl.sv
hw/rtl/dtr_dp.sv
hw/rtl/ds_twr_range_filter.sv
tb/sv/tb.sv
